/* rtl/jrd_pkg.sv */
package jrd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 14;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int HALF        = 1 << (FRAC_BITS - 1);

  // widths of the internal datapath (Q1.14 samples, 15 bit config fields)
  localparam int CFG_W    = 15;
  localparam int RANGE_W  = 16;
  localparam int SUM_W    = SAMPLE_BITS + 1;   // raw + offset
  localparam int MAG_W    = SAMPLE_BITS + 1;   // |axis| after offset rescale
  localparam int PNUM_W   = SUM_W + FRAC_BITS - 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int RSQ_W    = SQ_W + 1;
  localparam int ROOT_W   = (RSQ_W + 1) / 2;
  localparam int SC_W     = FRAC_BITS + 1;
  localparam int SDEN_W   = CFG_W + RANGE_W;
  localparam int SNUM_W   = ROOT_W + 2 * FRAC_BITS;
  localparam int ONUM_W   = MAG_W + SC_W;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_DEADZONE    = 3'd2,
    REG_RANGE_SCALE = 3'd3,
    REG_THRESHOLD_X = 3'd4,
    REG_THRESHOLD_Y = 3'd5,
    REG_INVERT_X    = 3'd6,
    REG_INVERT_Y    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PNUM_W-1:0] num;
    logic [CFG_W-1:0]  den;
    logic              neg;
  } prep_t;

endpackage

/* rtl/jrd_div.sv */
module jrd_div import jrd_pkg::*; #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 15,
  parameter int Q_W    = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] out_side
);

  // restoring divider, one quotient bit per stage, MSB first
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [W-1:0]      rem [Q_W];
  logic [DEN_W-1:0]  dv  [Q_W];
  logic [Q_W-1:0]    qv  [Q_W+1];
  logic [SIDE_W-1:0] sd  [Q_W+1];
  logic              vld [Q_W+1];

  assign rem[0] = W'(num);
  assign dv[0]  = den;
  assign qv[0]  = '0;
  assign sd[0]  = side;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic [W-1:0] trial;
    logic         take;

    assign trial = W'(dv[i]) << K;
    assign take  = rem[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qv[i+1] <= qv[i] | (Q_W'(take) << K);
        sd[i+1] <= sd[i];
      end
    end

    if (K > 0) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? rem[i] - trial : rem[i];
          dv[i+1]  <= dv[i];
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = qv[Q_W];
  assign out_side  = sd[Q_W];

endmodule

/* rtl/jrd_sqrt.sv */
module jrd_sqrt import jrd_pkg::*; #(
  parameter int IN_W   = 35,
  parameter int R_W    = 18,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   rad,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [R_W-1:0]    root,
  output logic [SIDE_W-1:0] out_side
);

  // digit by digit floor square root, one root bit per stage
  localparam int W = 2 * R_W + 1;

  logic [W-1:0]      rem [R_W];
  logic [R_W-1:0]    rt  [R_W+1];
  logic [SIDE_W-1:0] sd  [R_W+1];
  logic              vld [R_W+1];

  assign rem[0] = W'(rad);
  assign rt[0]  = '0;
  assign sd[0]  = side;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    localparam int K = R_W - 1 - i;
    logic [W-1:0] cand;
    logic         take;

    // (root + 2^K)^2 - root^2
    assign cand = (W'(rt[i]) << (K + 1)) + (W'(1'b1) << (2 * K));
    assign take = rem[i] >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[i+1] <= rt[i] | (R_W'(take) << K);
        sd[i+1] <= sd[i];
      end
    end

    if (K > 0) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? rem[i] - cand : rem[i];
        end
      end
    end
  end

  assign out_valid = vld[R_W];
  assign root      = rt[R_W];
  assign out_side  = sd[R_W];

endmodule

/* rtl/joystick_radial_deadzone.sv */
// Channel  Handshake               Payload
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (one register per beat)
// in       in_valid / in_stall     raw_x, raw_y
// out      out_valid / out_stall   stick_x, stick_y, dir_right/left/up/down
//
// One sample per cycle sustained while the output is not stalled. The pipe runs through
// the bit-per-stage units (17-stage offset divide, 18-stage sqrt, two 15-stage
// divides) plus the input, offset, square, sum, scale, product and output registers.
// rst is synchronous, clears every valid bit and returns the config registers to their defaults.
// The whole pipe advances when the output register is empty or being taken;
// otherwise in_stall rises and every beat holds in place, none lost.
module joystick_radial_deadzone import jrd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  // input samples
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] raw_x,
  input  logic signed [SAMPLE_BITS-1:0] raw_y,
  // conditioned output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] stick_x,
  output logic signed [SAMPLE_BITS-1:0] stick_y,
  output logic                          dir_right,
  output logic                          dir_left,
  output logic                          dir_up,
  output logic                          dir_down
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [CFG_W-1:0] offset_x, offset_y;
  logic [CFG_W-1:0]        deadzone, threshold_x, threshold_y;
  logic [RANGE_W-1:0]      range_scale;
  logic                    invert_x, invert_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      deadzone    <= '0;
      range_scale <= RANGE_W'(ONE);
      threshold_x <= CFG_W'(HALF);
      threshold_y <= CFG_W'(HALF);
      invert_x    <= 1'b0;
      invert_y    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_X:    offset_x    <= cfg_data[CFG_W-1:0];
        REG_OFFSET_Y:    offset_y    <= cfg_data[CFG_W-1:0];
        REG_DEADZONE:    deadzone    <= cfg_data[CFG_W-1:0];
        REG_RANGE_SCALE: range_scale <= cfg_data[RANGE_W-1:0];
        REG_THRESHOLD_X: threshold_x <= cfg_data[CFG_W-1:0];
        REG_THRESHOLD_Y: threshold_y <= cfg_data[CFG_W-1:0];
        REG_INVERT_X:    invert_x    <= cfg_data[0];
        REG_INVERT_Y:    invert_y    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // single advance for the whole pipe
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // stage A: input register
  // ---------------------------------------------------------------------
  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_raw_x, a_raw_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_raw_x <= raw_x;
      a_raw_y <= raw_y;
    end
  end

  // ---------------------------------------------------------------------
  // stage B: offset add, pick divisor (1 +- offset), build rounded dividend.
  // Offsets of a half or more skip the rescale: divide by one.
  // ---------------------------------------------------------------------
  function automatic prep_t axis_prep(input logic signed [SAMPLE_BITS-1:0] raw,
                                      input logic signed [CFG_W-1:0] off,
                                      input logic inv);
    logic signed [SUM_W-1:0] v;
    logic [SUM_W-1:0]        av;
    logic [CFG_W-1:0]        aoff;
    logic [CFG_W:0]          d;
    prep_t                   p;
    v    = SUM_W'(raw) + SUM_W'(off);
    av   = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    aoff = off[CFG_W-1] ? CFG_W'(-off) : CFG_W'(off);
    if (aoff < CFG_W'(HALF)) begin
      d     = (v > 0) ? (CFG_W+1)'(SUM_W'(ONE) + SUM_W'(off))
                      : (CFG_W+1)'(SUM_W'(ONE) - SUM_W'(off));
      p.num = (PNUM_W'(av) << FRAC_BITS) + PNUM_W'(d >> 1);
      p.den = CFG_W'(d);
    end else begin
      p.num = PNUM_W'(av);
      p.den = CFG_W'(1);
    end
    p.neg = v[SUM_W-1] ^ inv;
    return p;
  endfunction

  logic  b_valid;
  prep_t b_x, b_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x <= axis_prep(a_raw_x, offset_x, invert_x);
      b_y <= axis_prep(a_raw_y, offset_y, invert_y);
    end
  end

  // offset rescale dividers, one per axis, sign rides alongside
  logic             px_valid, py_valid;
  logic [MAG_W-1:0] px_mag, py_mag;
  logic             px_neg, py_neg;

  jrd_div #(.NUM_W(PNUM_W), .DEN_W(CFG_W), .Q_W(MAG_W), .SIDE_W(1)) u_div_px (
    .clk, .rst, .en,
    .in_valid (b_valid),
    .num      (b_x.num),
    .den      (b_x.den),
    .side     (b_x.neg),
    .out_valid(px_valid),
    .quo      (px_mag),
    .out_side (px_neg)
  );

  jrd_div #(.NUM_W(PNUM_W), .DEN_W(CFG_W), .Q_W(MAG_W), .SIDE_W(1)) u_div_py (
    .clk, .rst, .en,
    .in_valid (b_valid),
    .num      (b_y.num),
    .den      (b_y.den),
    .side     (b_y.neg),
    .out_valid(py_valid),
    .quo      (py_mag),
    .out_side (py_neg)
  );

  // ---------------------------------------------------------------------
  // stage C: squares of both axes and of the deadzone
  // ---------------------------------------------------------------------
  logic                 c_valid;
  logic [MAG_W-1:0]     c_mag_x, c_mag_y;
  logic                 c_neg_x, c_neg_y;
  logic [SQ_W-1:0]      c_sq_x, c_sq_y;
  logic [2*CFG_W-1:0]   c_dzsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= px_valid && py_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_mag_x <= px_mag;
      c_mag_y <= py_mag;
      c_neg_x <= px_neg;
      c_neg_y <= py_neg;
      c_sq_x  <= SQ_W'(px_mag) * SQ_W'(px_mag);
      c_sq_y  <= SQ_W'(py_mag) * SQ_W'(py_mag);
      c_dzsq  <= (2*CFG_W)'(deadzone) * (2*CFG_W)'(deadzone);
    end
  end

  // ---------------------------------------------------------------------
  // stage D: r^2 and the exact deadzone test
  // ---------------------------------------------------------------------
  logic [RSQ_W-1:0] rsq_sum;
  assign rsq_sum = RSQ_W'(c_sq_x) + RSQ_W'(c_sq_y);

  logic             d_valid;
  logic [RSQ_W-1:0] d_rsq;
  logic             d_kill;
  logic [MAG_W-1:0] d_mag_x, d_mag_y;
  logic             d_neg_x, d_neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rsq   <= rsq_sum;
      d_kill  <= (deadzone >= CFG_W'(ONE)) || (rsq_sum <= RSQ_W'(c_dzsq));
      d_mag_x <= c_mag_x;
      d_mag_y <= c_mag_y;
      d_neg_x <= c_neg_x;
      d_neg_y <= c_neg_y;
    end
  end

  // vector length
  localparam int RSIDE_W = 3 + 2 * MAG_W;

  logic               r_valid;
  logic [ROOT_W-1:0]  r_root;
  logic [RSIDE_W-1:0] r_side;
  logic               r_kill, r_neg_x, r_neg_y;
  logic [MAG_W-1:0]   r_mag_x, r_mag_y;

  jrd_sqrt #(.IN_W(RSQ_W), .R_W(ROOT_W), .SIDE_W(RSIDE_W)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (d_valid),
    .rad      (d_rsq),
    .side     ({d_kill, d_neg_x, d_mag_x, d_neg_y, d_mag_y}),
    .out_valid(r_valid),
    .root     (r_root),
    .out_side (r_side)
  );

  assign {r_kill, r_neg_x, r_mag_x, r_neg_y, r_mag_y} = r_side;

  // ---------------------------------------------------------------------
  // stage E: (r - dz) and (1 - dz) * range
  // ---------------------------------------------------------------------
  logic [RANGE_W-1:0] rng;
  assign rng = (range_scale == '0) ? RANGE_W'(1) : range_scale;

  logic              e_valid;
  logic [ROOT_W-1:0] e_rd, e_root;
  logic [SDEN_W-1:0] e_den;
  logic              e_kill, e_neg_x, e_neg_y;
  logic [MAG_W-1:0]  e_mag_x, e_mag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_rd    <= r_root - ROOT_W'(deadzone);
      e_den   <= SDEN_W'(CFG_W'(ONE) - deadzone) * SDEN_W'(rng);
      e_root  <= r_root;
      e_kill  <= r_kill;
      e_neg_x <= r_neg_x;
      e_neg_y <= r_neg_y;
      e_mag_x <= r_mag_x;
      e_mag_y <= r_mag_y;
    end
  end

  // scaled length: s = (r-dz)*ONE*ONE / den. Saturates at ONE when s would
  // not fit SC_W bits; the divider's out-of-range quotient is then ignored.
  localparam int SSIDE_W = 2 + ROOT_W + 2 + 2 * MAG_W;

  logic                 e_sat;
  logic [SNUM_W-1:0]    e_num;
  logic [SSIDE_W-1:0]   s_side;
  logic                 s_valid;
  logic [SC_W-1:0]      s_quo;
  logic                 s_kill, s_sat, s_neg_x, s_neg_y;
  logic [ROOT_W-1:0]    s_root;
  logic [MAG_W-1:0]     s_mag_x, s_mag_y;

  assign e_sat = (SDEN_W'(e_rd) << (2 * FRAC_BITS - SC_W)) >= e_den;
  assign e_num = SNUM_W'(e_rd) << (2 * FRAC_BITS);

  jrd_div #(.NUM_W(SNUM_W), .DEN_W(SDEN_W), .Q_W(SC_W), .SIDE_W(SSIDE_W)) u_div_scale (
    .clk, .rst, .en,
    .in_valid (e_valid),
    .num      (e_num),
    .den      (e_den),
    .side     ({e_kill, e_sat, e_root, e_neg_x, e_mag_x, e_neg_y, e_mag_y}),
    .out_valid(s_valid),
    .quo      (s_quo),
    .out_side (s_side)
  );

  assign {s_kill, s_sat, s_root, s_neg_x, s_mag_x, s_neg_y, s_mag_y} = s_side;

  // ---------------------------------------------------------------------
  // stage G: clamp to unit length, axis * scale + r/2 for rounding
  // ---------------------------------------------------------------------
  logic [SC_W-1:0] sc;
  assign sc = (s_sat || s_quo > SC_W'(ONE)) ? SC_W'(ONE) : s_quo;

  logic              g_valid;
  logic [ONUM_W-1:0] g_num_x, g_num_y;
  logic [ROOT_W-1:0] g_root;
  logic              g_kill, g_neg_x, g_neg_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_num_x <= ONUM_W'(s_mag_x) * ONUM_W'(sc) + ONUM_W'(s_root >> 1);
      g_num_y <= ONUM_W'(s_mag_y) * ONUM_W'(sc) + ONUM_W'(s_root >> 1);
      g_root  <= s_root;
      g_kill  <= s_kill;
      g_neg_x <= s_neg_x;
      g_neg_y <= s_neg_y;
    end
  end

  // per-axis divide by r
  logic            ox_valid, oy_valid;
  logic [SC_W-1:0] ox_mag, oy_mag;
  logic            ox_kill, ox_neg, oy_neg;

  jrd_div #(.NUM_W(ONUM_W), .DEN_W(ROOT_W), .Q_W(SC_W), .SIDE_W(2)) u_div_ox (
    .clk, .rst, .en,
    .in_valid (g_valid),
    .num      (g_num_x),
    .den      (g_root),
    .side     ({g_kill, g_neg_x}),
    .out_valid(ox_valid),
    .quo      (ox_mag),
    .out_side ({ox_kill, ox_neg})
  );

  jrd_div #(.NUM_W(ONUM_W), .DEN_W(ROOT_W), .Q_W(SC_W), .SIDE_W(1)) u_div_oy (
    .clk, .rst, .en,
    .in_valid (g_valid),
    .num      (g_num_y),
    .den      (g_root),
    .side     (g_neg_y),
    .out_valid(oy_valid),
    .quo      (oy_mag),
    .out_side (oy_neg)
  );

  // ---------------------------------------------------------------------
  // output register: sign, deadzone zeroing, direction flags
  // ---------------------------------------------------------------------
  logic [SC_W-1:0] fx_mag, fy_mag;
  assign fx_mag = ox_kill ? '0 : ox_mag;
  assign fy_mag = ox_kill ? '0 : oy_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ox_valid && oy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stick_x   <= ox_neg ? -SAMPLE_BITS'(fx_mag) : SAMPLE_BITS'(fx_mag);
      stick_y   <= oy_neg ? -SAMPLE_BITS'(fy_mag) : SAMPLE_BITS'(fy_mag);
      dir_right <= !ox_neg && (fx_mag > threshold_x);
      dir_left  <=  ox_neg && (fx_mag > threshold_x);
      dir_up    <= !oy_neg && (fy_mag > threshold_y);
      dir_down  <=  oy_neg && (fy_mag > threshold_y);
    end
  end

endmodule
